// File: rtl/falling_sand_grid_step_defines.svh
// Assertion macros shared by the RTL.
`ifndef FALLING_SAND_GRID_STEP_DEFINES_SVH
`define FALLING_SAND_GRID_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FSG_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FSG_ASSERT(label, prop, msg) \
   `FSG_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define FSG_ASSERT_CLK(label, clk, rst, prop, msg)
`define FSG_ASSERT(label, prop, msg)
`endif

`endif

// File: rtl/fsg_pkg.sv
`timescale 1ns / 1ps
package fsg_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 128;

   // columns resolved per scan cycle
   localparam int LANES     = 8;
   localparam int CHUNKS    = (GRID_WIDTH + LANES - 1) / LANES;
   localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int COL_W     = $clog2(GRID_WIDTH);
   localparam int ROW_W     = $clog2(GRID_HEIGHT);
   localparam int EXT_W     = CHUNKS * LANES + 2;
   localparam int CUR_EXT_W = CHUNKS * LANES;

   localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS - 1);

   localparam logic [1:0] MODE_SET  = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   typedef logic [GRID_WIDTH-1:0] row_type;

endpackage

// File: rtl/fsg_ram.sv
`timescale 1ns / 1ps
module fsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/falling_sand_grid_step.sv
`timescale 1ns / 1ps
// Falling-sand grid of GRID_WIDTH x GRID_HEIGHT one-bit cells, held as one row per word in a
// dual-port RAM, all cells empty after reset. A request sets a cell, reads a cell or runs one
// tick; every request gives exactly one response. A tick walks rows bottom-up: each row is
// read, resolved eight columns per cycle against the row below it (kept in registers), then
// written back: after each scan, the finished row below is written while the next row up is
// read. No request is taken while one is in progress; a finished response may wait in the
// output register.
`include "falling_sand_grid_step_defines.svh"
module falling_sand_grid_step
   import fsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // mode[1:0], cell_x[9:2], cell_y[16:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // cell_value[0], zero pad
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RD      = 3'd1;
   localparam logic [2:0] ST_TLOAD_B = 3'd2;
   localparam logic [2:0] ST_TLOAD_C = 3'd3;
   localparam logic [2:0] ST_SCAN    = 3'd4;
   localparam logic [2:0] ST_TWB     = 3'd5;
   localparam logic [2:0] ST_TLAST   = 3'd6;
   localparam logic [2:0] ST_FIN     = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               inside_ff, inside_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   row_type            below_ff, below_in;
   row_type            cur_ff, cur_in;
   logic               res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_value_ff, rsp_value_in;
   logic [GRID_HEIGHT-1:0] row_valid_ff;
   logic               rd_valid_ff;

   logic               wr_en, rd_en;
   logic [ROW_W-1:0]   wr_addr, rd_addr;
   row_type            wr_data, rd_data, rd_row;
   row_type            below_scan, cur_scan;

   logic               req_fire;
   logic [1:0]         req_mode;
   logic [7:0]         req_cell_x;
   logic [6:0]         req_cell_y;
   logic               req_inside;

   assign req_mode   = req_tdata[1:0];
   assign req_cell_x = req_tdata[9:2];
   assign req_cell_y = req_tdata[16:10];
   assign req_inside = (32'(req_cell_x) < 32'(GRID_WIDTH)) &&
                       (32'(req_cell_y) < 32'(GRID_HEIGHT));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   fsg_ram #(
      .WIDTH (GRID_WIDTH),
      .DEPTH (GRID_HEIGHT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rows never written read as empty
   assign rd_row = rd_data & {GRID_WIDTH{rd_valid_ff}};

   // resolve one group of columns of the current row against the row below
   always_comb begin
      logic [EXT_W-1:0]     ext;
      logic [CUR_EXT_W-1:0] cur_ext;
      logic [LANES+1:0]     win;
      logic [LANES-1:0]     cwin;
      int                   base;
      base    = int'(chunk_ff) * LANES;
      // outside the grid counts as blocked
      ext     = {{(EXT_W-GRID_WIDTH-1){1'b1}}, below_ff, 1'b1};
      cur_ext = {{(CUR_EXT_W-GRID_WIDTH){1'b0}}, cur_ff};
      win     = ext[base +: LANES+2];
      cwin    = cur_ext[base +: LANES];
      for (int k = 0; k < LANES; k++) begin
         if (cwin[k]) begin
            if (!win[k+1]) begin
               win[k+1] = 1'b1;
               cwin[k]  = 1'b0;
            end else if (!win[k]) begin
               win[k]  = 1'b1;
               cwin[k] = 1'b0;
            end else if (!win[k+2]) begin
               win[k+2] = 1'b1;
               cwin[k]  = 1'b0;
            end
         end
      end
      ext[base +: LANES+2]  = win;
      cur_ext[base +: LANES] = cwin;
      below_scan = ext[GRID_WIDTH:1];
      cur_scan   = cur_ext[GRID_WIDTH-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      inside_in    = inside_ff;
      chunk_in     = chunk_ff;
      below_in     = below_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = below_ff;
      rd_en        = 1'b0;
      rd_addr      = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in   = req_mode;
               col_in    = COL_W'(req_cell_x);
               inside_in = req_inside;
               rd_en     = 1'b1;
               if (req_mode == MODE_TICK) begin
                  rd_addr  = ROW_W'(GRID_HEIGHT - 1);
                  row_in   = ROW_W'(GRID_HEIGHT - 2);
                  state_in = ST_TLOAD_B;
               end else begin
                  rd_addr  = ROW_W'(req_cell_y);
                  row_in   = ROW_W'(req_cell_y);
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            res_in  = (mode_ff == MODE_READ) && inside_ff && rd_row[col_ff];
            wr_en   = (mode_ff == MODE_SET) && inside_ff;
            wr_data = rd_row | (row_type'(1) << col_ff);
            state_in = ST_FIN;
         end
         ST_TLOAD_B: begin
            below_in = rd_row;
            rd_en    = 1'b1;
            state_in = ST_TLOAD_C;
         end
         ST_TLOAD_C: begin
            cur_in   = rd_row;
            chunk_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            below_in = below_scan;
            cur_in   = cur_scan;
            if (chunk_ff == CHUNK_LAST) begin
               state_in = ST_TWB;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_TWB: begin
            // retire the finished lower row, fetch the next one up
            wr_en    = 1'b1;
            wr_addr  = row_ff + 1'b1;
            below_in = cur_ff;
            if (row_ff == '0) begin
               state_in = ST_TLAST;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = row_ff - 1'b1;
               row_in   = row_ff - 1'b1;
               state_in = ST_TLOAD_C;
            end
         end
         ST_TLAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            res_in   = 1'b0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      inside_ff    <= inside_in;
      chunk_ff     <= chunk_in;
      below_ff     <= below_in;
      cur_ff       <= cur_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_value_ff};

   `FSG_ASSERT(a_no_rw_same_row, !(wr_en && rd_en && (wr_addr == rd_addr)), "row clash")
   `FSG_ASSERT(a_rsp_from_fin, $rose(rsp_tvalid) |-> $past(state_ff == ST_FIN), "stray response")
   `FSG_ASSERT(a_chunk_range, (state_ff == ST_SCAN) |-> (chunk_ff <= CHUNK_LAST), "bad chunk")
   `FSG_ASSERT(a_busy_after_req, req_fire |=> !req_tready, "request taken while busy")

endmodule
